// ===== rtl/etc_pkg.sv =====
// Shared types, constants and character-class helpers for the expression token scanner.
// Used by every rtl file but etc_ram; depends on nothing.
package etc_pkg;

  // Sizing
  localparam int unsigned LexemeLimit  = 32;
  localparam int unsigned PositionBits = 16;
  localparam int unsigned LexMax       = LexemeLimit - 1;
  localparam int unsigned LenW         = $clog2(LexemeLimit);
  localparam int unsigned AddrW        = LenW + 1;
  localparam int unsigned FifoDepth    = 4;
  localparam int unsigned FifoPtrW     = $clog2(FifoDepth);
  localparam int unsigned FifoCntW     = $clog2(FifoDepth + 1);
  localparam bit          LimitAbove1  = (LexMax > 1);

  typedef logic [PositionBits-1:0] pos_t;
  typedef logic [LenW-1:0]         len_t;
  typedef logic [AddrW-1:0]        addr_t;

  localparam pos_t PosMax = '1;
  localparam pos_t PosOne = pos_t'(1);
  localparam len_t LenMax = len_t'(LexMax);

  // Characters of interest
  localparam logic [7:0] ChUnder   = 8'h5F;
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChMinus   = 8'h2D;
  localparam logic [7:0] ChStar    = 8'h2A;
  localparam logic [7:0] ChSlash   = 8'h2F;
  localparam logic [7:0] ChLParen  = 8'h28;
  localparam logic [7:0] ChRParen  = 8'h29;
  localparam logic [7:0] ChEquals  = 8'h3D;
  localparam logic [7:0] ChSemi    = 8'h3B;
  localparam logic [7:0] ChDollar  = 8'h24;

  typedef enum logic [3:0] {
    KIND_ID        = 4'd0,
    KIND_NUMBER    = 4'd1,
    KIND_PLUS      = 4'd2,
    KIND_MINUS     = 4'd3,
    KIND_MULTIPLY  = 4'd4,
    KIND_DIVIDE    = 4'd5,
    KIND_LPAREN    = 4'd6,
    KIND_RPAREN    = 4'd7,
    KIND_ASSIGN    = 4'd8,
    KIND_SEMICOLON = 4'd9,
    KIND_EOF       = 4'd10,
    KIND_UNKNOWN   = 4'd11
  } tok_kind_e;

  typedef enum logic [1:0] {
    CLS_NONE,
    CLS_ID,
    CLS_NUM
  } cls_e;

  typedef enum logic {
    FRONT_IDLE,
    FRONT_SECOND
  } front_state_e;

  typedef enum logic [1:0] {
    BACK_IDLE,
    BACK_READ,
    BACK_WAIT,
    BACK_SINGLE
  } back_state_e;

  // Channel payloads
  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    tok_kind_e   token_kind;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic [4:0]  char_position;
    logic [7:0]  lexeme_byte;
    logic        token_done;
    logic        run_done;
  } out_item_t;

  // Command from front to back: either replay a buffered token or send one character
  typedef struct packed {
    logic       is_flush;
    logic       last;
    tok_kind_e  kind;
    pos_t       line;
    pos_t       col;
    logic [7:0] chr;
    len_t       len;
    logic       bank;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic room2;
  } fifo_stat_t;

  typedef struct packed {
    logic       en;
    addr_t      addr;
    logic [7:0] data;
  } ram_wr_t;

  typedef struct packed {
    logic  en;
    addr_t addr;
  } ram_rd_t;

  function automatic logic is_space(logic [7:0] c);
    return c inside {8'd32, [8'd9:8'd13]};
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
  endfunction

  function automatic tok_kind_e op_kind(logic [7:0] c);
    tok_kind_e k;
    case (c)
      ChPlus:   k = KIND_PLUS;
      ChMinus:  k = KIND_MINUS;
      ChStar:   k = KIND_MULTIPLY;
      ChSlash:  k = KIND_DIVIDE;
      ChLParen: k = KIND_LPAREN;
      ChRParen: k = KIND_RPAREN;
      ChEquals: k = KIND_ASSIGN;
      ChSemi:   k = KIND_SEMICOLON;
      default:  k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

  function automatic pos_t sat_inc(pos_t v);
    return (v == PosMax) ? v : v + PosOne;
  endfunction

  // Fit a position or index into a fixed output field
  function automatic logic [15:0] pos_field(pos_t v);
    logic [31:0] w;
    w = 32'(v);
    return w[15:0];
  endfunction

  function automatic logic [4:0] idx_field(len_t v);
    logic [31:0] w;
    w = 32'(v);
    return w[4:0];
  endfunction

endpackage

// ===== rtl/etc_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module etc_ram #(
  parameter int unsigned AW = 6,
  parameter int unsigned DW = 8
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o
);

  logic [DW-1:0] mem_q [2**AW];
  logic [DW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/etc_front.sv =====
// Front end: accepts input beats, classifies characters, tracks position and
// builds tokens in the character RAM. Issues commands to the back end. Uses etc_pkg.
module etc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  etc_pkg::in_item_t   in_i,
  output logic                push_o,
  output etc_pkg::cmd_t       cmd_o,
  input  etc_pkg::fifo_stat_t fifo_stat_i,
  input  logic                flush_done_i,
  output etc_pkg::ram_wr_t    ram_wr_o
);

  etc_pkg::front_state_e state_q, state_d;
  etc_pkg::cls_e         cls_q, cls_d;
  etc_pkg::len_t         len_q, len_d;
  etc_pkg::pos_t         tok_line_q, tok_line_d, tok_col_q, tok_col_d;
  etc_pkg::pos_t         cur_line_q, cur_line_d, cur_col_q, cur_col_d;
  logic                  bank_q, bank_d;
  logic                  busy_q, busy_d;
  etc_pkg::cmd_t         cmd_b_q, cmd_b_d;

  logic          accept;
  logic [7:0]    c;
  logic          eot, word, ext, pre_flush, single, append, append_start, limit_hit;
  logic          wr_bank, has_tail;
  etc_pkg::len_t new_len;
  etc_pkg::cls_e word_cls;
  etc_pkg::cmd_t pre_cmd, tail_cmd, cmd_a;

  // Classification of the offered beat
  assign c            = in_i.text_byte;
  assign eot          = in_i.end_of_text;
  assign word         = etc_pkg::is_alpha(c) | etc_pkg::is_digit(c) | (c == etc_pkg::ChUnder);
  assign ext          = !eot && (((cls_q == etc_pkg::CLS_ID) && word) ||
                                 ((cls_q == etc_pkg::CLS_NUM) && etc_pkg::is_digit(c)));
  assign pre_flush    = !ext && (cls_q != etc_pkg::CLS_NONE);
  assign single       = eot || (!etc_pkg::is_space(c) && !word);
  assign append       = !eot && (ext || word);
  assign append_start = append && !ext;
  assign new_len      = (append_start ? '0 : len_q) + etc_pkg::len_t'(1);
  assign limit_hit    = append && (new_len == etc_pkg::LenMax);
  assign has_tail     = single || limit_hit;
  assign wr_bank      = bank_q ^ pre_flush;
  assign word_cls     = ext ? cls_q :
                        (etc_pkg::is_digit(c) ? etc_pkg::CLS_NUM : etc_pkg::CLS_ID);

  // Ready: one beat at a time, room for two commands, and a flush only when
  // the other RAM bank has finished its replay
  assign in_ready_o = (state_q == etc_pkg::FRONT_IDLE) && fifo_stat_i.room2 &&
                      (!busy_q || ((cls_q == etc_pkg::CLS_NONE) && etc_pkg::LimitAbove1));
  assign accept     = in_valid_i && in_ready_o;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      etc_pkg::FRONT_IDLE: begin
        if (accept && pre_flush && has_tail) begin
          state_d = etc_pkg::FRONT_SECOND;
        end
      end
      etc_pkg::FRONT_SECOND: begin
        state_d = etc_pkg::FRONT_IDLE;
      end
      default: state_d = etc_pkg::FRONT_IDLE;
    endcase
  end

  // Command building
  always_comb begin
    pre_cmd.is_flush = 1'b1;
    pre_cmd.last     = !has_tail;
    pre_cmd.kind     = (cls_q == etc_pkg::CLS_NUM) ? etc_pkg::KIND_NUMBER : etc_pkg::KIND_ID;
    pre_cmd.line     = tok_line_q;
    pre_cmd.col      = tok_col_q;
    pre_cmd.chr      = c;
    pre_cmd.len      = len_q;
    pre_cmd.bank     = bank_q;

    tail_cmd.last     = 1'b1;
    tail_cmd.bank     = wr_bank;
    tail_cmd.len      = etc_pkg::LenMax;
    if (single) begin
      tail_cmd.is_flush = 1'b0;
      tail_cmd.kind     = eot ? etc_pkg::KIND_EOF : etc_pkg::op_kind(c);
      tail_cmd.line     = cur_line_q;
      tail_cmd.col      = cur_col_q;
      tail_cmd.chr      = eot ? etc_pkg::ChDollar : c;
    end else begin
      // token cut at the lexeme limit
      tail_cmd.is_flush = 1'b1;
      tail_cmd.kind     = (word_cls == etc_pkg::CLS_NUM) ? etc_pkg::KIND_NUMBER :
                                                            etc_pkg::KIND_ID;
      tail_cmd.line     = append_start ? cur_line_q : tok_line_q;
      tail_cmd.col      = append_start ? cur_col_q : tok_col_q;
      tail_cmd.chr      = c;
    end

    cmd_a   = pre_flush ? pre_cmd : tail_cmd;
    cmd_b_d = (accept && pre_flush && has_tail) ? tail_cmd : cmd_b_q;
  end

  // Outputs to queue and RAM
  always_comb begin
    push_o = 1'b0;
    cmd_o  = cmd_a;
    case (state_q)
      etc_pkg::FRONT_IDLE: begin
        push_o = accept && (pre_flush || has_tail);
      end
      etc_pkg::FRONT_SECOND: begin
        push_o = 1'b1;
        cmd_o  = cmd_b_q;
      end
      default: push_o = 1'b0;
    endcase
    ram_wr_o.en   = accept && append;
    ram_wr_o.addr = {wr_bank, (append_start ? etc_pkg::len_t'(0) : len_q)};
    ram_wr_o.data = c;
  end

  // Token and position state
  always_comb begin
    cls_d      = cls_q;
    len_d      = len_q;
    tok_line_d = tok_line_q;
    tok_col_d  = tok_col_q;
    cur_line_d = cur_line_q;
    cur_col_d  = cur_col_q;
    bank_d     = bank_q;
    busy_d     = (busy_q && !flush_done_i) || (push_o && cmd_o.is_flush);
    if (accept) begin
      bank_d = bank_q ^ pre_flush ^ limit_hit;
      if (eot) begin
        cls_d      = etc_pkg::CLS_NONE;
        len_d      = '0;
        tok_line_d = etc_pkg::PosOne;
        tok_col_d  = etc_pkg::PosOne;
        cur_line_d = etc_pkg::PosOne;
        cur_col_d  = etc_pkg::PosOne;
      end else if (append) begin
        cls_d     = limit_hit ? etc_pkg::CLS_NONE : word_cls;
        len_d     = limit_hit ? '0 : new_len;
        cur_col_d = etc_pkg::sat_inc(cur_col_q);
        if (append_start) begin
          tok_line_d = cur_line_q;
          tok_col_d  = cur_col_q;
        end
      end else begin
        cls_d = etc_pkg::CLS_NONE;
        len_d = '0;
        if (etc_pkg::is_space(c)) begin
          if (c == etc_pkg::ChNewline) begin
            cur_line_d = etc_pkg::sat_inc(cur_line_q);
            cur_col_d  = etc_pkg::PosOne;
          end else begin
            cur_col_d = etc_pkg::sat_inc(cur_col_q);
          end
        end else begin
          tok_line_d = cur_line_q;
          tok_col_d  = cur_col_q;
          cur_col_d  = etc_pkg::sat_inc(cur_col_q);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= etc_pkg::FRONT_IDLE;
      cls_q      <= etc_pkg::CLS_NONE;
      len_q      <= '0;
      tok_line_q <= etc_pkg::PosOne;
      tok_col_q  <= etc_pkg::PosOne;
      cur_line_q <= etc_pkg::PosOne;
      cur_col_q  <= etc_pkg::PosOne;
      bank_q     <= 1'b0;
      busy_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      cls_q      <= cls_d;
      len_q      <= len_d;
      tok_line_q <= tok_line_d;
      tok_col_q  <= tok_col_d;
      cur_line_q <= cur_line_d;
      cur_col_q  <= cur_col_d;
      bank_q     <= bank_d;
      busy_q     <= busy_d;
    end
  end

  // Held second command, payload only
  always_ff @(posedge clk_i) begin
    cmd_b_q <= cmd_b_d;
  end

endmodule

// ===== rtl/etc_cmd_fifo.sv =====
// Small command queue between front and back end.
// Uses etc_pkg for the command type and depth.
module etc_cmd_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  etc_pkg::cmd_t       cmd_i,
  input  logic                pop_i,
  output etc_pkg::cmd_t       head_o,
  output etc_pkg::fifo_stat_t stat_o
);

  etc_pkg::cmd_t                  slot_q [etc_pkg::FifoDepth];
  logic [etc_pkg::FifoPtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [etc_pkg::FifoCntW-1:0]   count_q, count_d;

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  assign head_o       = slot_q[rd_ptr_q];
  assign stat_o.empty = (count_q == '0);
  assign stat_o.room2 = (count_q <= etc_pkg::FifoCntW'(etc_pkg::FifoDepth - 2));

endmodule

// ===== rtl/etc_back.sv =====
// Back end: pops commands, replays buffered tokens from the character RAM and
// drives the registered result beat. Uses etc_pkg.
module etc_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  etc_pkg::cmd_t        head_i,
  input  etc_pkg::fifo_stat_t  fifo_stat_i,
  output logic                 pop_o,
  output etc_pkg::ram_rd_t     ram_rd_o,
  input  logic [7:0]           rd_data_i,
  output logic                 flush_done_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output etc_pkg::out_item_t   out_o
);

  etc_pkg::back_state_e state_q, state_d;
  etc_pkg::cmd_t        cmd_q, cmd_d;
  etc_pkg::len_t        idx_q, idx_d;
  logic                 out_valid_q, out_valid_d;
  etc_pkg::out_item_t   out_q, out_d;

  logic slot_free, last_char, load;

  assign slot_free = !out_valid_q || out_ready_i;
  assign last_char = (idx_q == etc_pkg::len_t'(cmd_q.len - etc_pkg::len_t'(1)));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      etc_pkg::BACK_IDLE: begin
        if (!fifo_stat_i.empty) begin
          state_d = head_i.is_flush ? etc_pkg::BACK_READ : etc_pkg::BACK_SINGLE;
        end
      end
      etc_pkg::BACK_READ: begin
        state_d = etc_pkg::BACK_WAIT;
      end
      etc_pkg::BACK_WAIT: begin
        if (slot_free) begin
          state_d = last_char ? etc_pkg::BACK_IDLE : etc_pkg::BACK_READ;
        end
      end
      etc_pkg::BACK_SINGLE: begin
        if (slot_free) begin
          state_d = etc_pkg::BACK_IDLE;
        end
      end
      default: state_d = etc_pkg::BACK_IDLE;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    pop_o         = 1'b0;
    ram_rd_o.en   = 1'b0;
    ram_rd_o.addr = {cmd_q.bank, idx_q};
    load          = 1'b0;
    flush_done_o  = 1'b0;
    cmd_d         = cmd_q;
    idx_d         = idx_q;
    case (state_q)
      etc_pkg::BACK_IDLE: begin
        pop_o = !fifo_stat_i.empty;
        if (!fifo_stat_i.empty) begin
          cmd_d = head_i;
          idx_d = '0;
        end
      end
      etc_pkg::BACK_READ: begin
        ram_rd_o.en = 1'b1;
      end
      etc_pkg::BACK_WAIT: begin
        load         = slot_free;
        flush_done_o = slot_free && last_char;
        if (slot_free && !last_char) begin
          idx_d = idx_q + etc_pkg::len_t'(1);
        end
      end
      etc_pkg::BACK_SINGLE: begin
        load = slot_free;
      end
      default: load = 1'b0;
    endcase

    out_d.token_kind    = cmd_q.kind;
    out_d.start_line    = etc_pkg::pos_field(cmd_q.line);
    out_d.start_column  = etc_pkg::pos_field(cmd_q.col);
    out_d.char_position = etc_pkg::idx_field(idx_q);
    out_d.lexeme_byte   = (state_q == etc_pkg::BACK_WAIT) ? rd_data_i : cmd_q.chr;
    out_d.token_done    = (state_q == etc_pkg::BACK_SINGLE) || last_char;
    out_d.run_done      = cmd_q.last && out_d.token_done;
    if (!load) begin
      out_d = out_q;
    end
    out_valid_d = load || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= etc_pkg::BACK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    idx_q <= idx_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ===== rtl/expression_token_scanner.sv =====
// Top level of the expression token scanner: front end, command queue, two-bank
// character RAM and back end. Uses etc_pkg, etc_front, etc_cmd_fifo, etc_ram, etc_back.
//
//   channel | direction | handshake            | beat payload
//   in      | input     | in_valid_i/in_ready_o | etc_pkg::in_item_t  (byte, end marker)
//   out     | output    | out_valid_o/out_ready_i | etc_pkg::out_item_t (one lexeme char)
//
// Front end: one input beat per cycle, but a beat that closes a pending token and
// also yields an operator, unknown or EOF result holds input during FRONT_SECOND.
// Back end: takes a command in IDLE, then per lexeme character a RAM read (READ) and
// an output load (WAIT); a single character is loaded in SINGLE, then back to IDLE.
// Input stalls while the queue lacks room for two commands, or while a replay runs
// and a token is pending in the other bank. Result stalls add to the back end time.
// Reset is asynchronous, active low; the character RAM needs no clearing.
module expression_token_scanner (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  etc_pkg::in_item_t  in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output etc_pkg::out_item_t out_o
);

  logic                push, pop, flush_done;
  etc_pkg::cmd_t       cmd, head;
  etc_pkg::fifo_stat_t fifo_stat;
  etc_pkg::ram_wr_t    ram_wr;
  etc_pkg::ram_rd_t    ram_rd;
  logic [7:0]          rd_data;

  etc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_i         (in_i),
    .push_o       (push),
    .cmd_o        (cmd),
    .fifo_stat_i  (fifo_stat),
    .flush_done_i (flush_done),
    .ram_wr_o     (ram_wr)
  );

  etc_cmd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (cmd),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (fifo_stat)
  );

  etc_ram #(
    .AW (etc_pkg::AddrW),
    .DW (8)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr.en),
    .wr_addr_i (ram_wr.addr),
    .wr_data_i (ram_wr.data),
    .rd_en_i   (ram_rd.en),
    .rd_addr_i (ram_rd.addr),
    .rd_data_o (rd_data)
  );

  etc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .fifo_stat_i  (fifo_stat),
    .pop_o        (pop),
    .ram_rd_o     (ram_rd),
    .rd_data_i    (rd_data),
    .flush_done_o (flush_done),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_o        (out_o)
  );

endmodule

// ===== rtl/etc_checker.sv =====
// Port-level checks for the expression token scanner, bound to the top level.
// Uses etc_pkg for payload types and codes.
module etc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input etc_pkg::in_item_t  in_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input etc_pkg::out_item_t out_o
);

  logic in_beat;
  assign in_beat = in_valid_i && in_ready_o && in_i.end_of_text;

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("result beat changed while stalled");

  // The final result of a step always closes a token
  a_run_closes_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.run_done |-> out_o.token_done)
    else $error("run_done without token_done");

  // EOF is a lone dollar that ends the step
  a_eof_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.token_kind == etc_pkg::KIND_EOF) |->
      out_o.run_done && (out_o.char_position == 5'd0) &&
      (out_o.lexeme_byte == etc_pkg::ChDollar))
    else $error("malformed EOF result");

  // Operators and unknown bytes are single-character tokens
  a_single_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.token_kind != etc_pkg::KIND_ID) &&
    (out_o.token_kind != etc_pkg::KIND_NUMBER) |->
      out_o.token_done && (out_o.char_position == 5'd0))
    else $error("multi-character operator token");

  // After a non-final character the next result continues the same lexeme
  a_lexeme_order: assert property (@(posedge clk_i) disable iff (!rst_ni || in_beat)
    out_valid_o && out_ready_i && !out_o.token_done |=>
      !out_valid_o ||
      ((out_o.char_position == $past(out_o.char_position) + 5'd1) &&
       (out_o.token_kind == $past(out_o.token_kind))))
    else $error("lexeme characters out of order");

endmodule

bind expression_token_scanner etc_checker u_etc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_i        (in_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_o       (out_o)
);
